FILE: design/radix2_complex_fft_defines.svh
// Assertion macros shared by the checker of the radix-2 FFT block.
// Expects clk_i and rst_ni in scope where the macros are used.
`ifndef RADIX2_COMPLEX_FFT_DEFINES_SVH
`define RADIX2_COMPLEX_FFT_DEFINES_SVH

// same-cycle implication
`define R2FFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("r2fft check failed");

// next-cycle implication
`define R2FFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("r2fft check failed");

`endif

FILE: design/r2fft_pkg.sv
// Package for the radix-2 FFT block: sizes, codes, controller types,
// command/status structs and the quarter-wave sine ROM. No dependencies.
package r2fft_pkg;

  localparam int MAX_LOG_SIZE  = 10;
  localparam int SAMPLE_BITS   = 16;
  localparam int TWIDDLE_BITS  = 16;
  localparam int INTERNAL_BITS = 28;

  localparam int ADDR_BITS = MAX_LOG_SIZE;
  localparam int FULL_N    = 1 << MAX_LOG_SIZE;
  localparam int QUART_N   = FULL_N / 4;
  localparam int LOG_BITS  = 4;
  localparam int ACC_BITS  = INTERNAL_BITS + 4;
  localparam int WORD_BITS = 2 * INTERNAL_BITS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 4;
  localparam int TW_SHIFT  = 32 - TWIDDLE_BITS;

  localparam longint unsigned PI_Q31 = 64'd6746518852;

  localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE_MODE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOG_SIZE     = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_BR_RA,
    ST_BR_RB,
    ST_BR_WA,
    ST_BR_WB,
    ST_BF_RA,
    ST_BF_RB,
    ST_BF_MUL,
    ST_BF_WT,
    ST_BF_WB
  } state_e;

  typedef struct packed {
    logic load_acc;
    logic read_acc;
    logic read_out;
    logic br_rd_a;
    logic br_rd_b;
    logic br_wr_a;
    logic br_wr_b;
    logic br_skip;
    logic bf_rd_a;
    logic bf_rd_b;
    logic bf_mul;
    logic bf_wr_t;
    logic bf_wr_b;
  } cmd_t;

  typedef struct packed {
    logic load_full;
    logic frame_ready;
    logic out_free;
    logic br_swap;
    logic br_last;
    logic mul_done;
    logic bf_last;
    logic stage_last;
  } stat_t;

  typedef logic [TWIDDLE_BITS-1:0] sin_rom_t [QUART_N+1];

  // shift-and-subtract quotient, only evaluated while building the ROM
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Taylor series in Q31, angle in [0, pi/4]; odd selects sine
  function automatic longint unsigned series_q31(longint unsigned x, bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned d;
    longint          sum;
    x2   = (x * x) >> 31;
    term = odd ? x : (64'd1 << 31);
    sum  = longint'(term);
    for (int i = 1; i < 24; i++) begin
      if (term != 0) begin
        d = odd ? longint'(2 * i) * longint'(2 * i + 1)
                : longint'(2 * i - 1) * longint'(2 * i);
        term = div_u64((term * x2) >> 31, d);
        if ((i & 1) != 0) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic longint unsigned to_twiddle(longint unsigned q31);
    longint unsigned r;
    longint unsigned top;
    top = (64'd1 << (TWIDDLE_BITS - 1)) - 64'd1;
    r   = q31;
    if (TW_SHIFT > 0) r = (q31 + (64'd1 << (TW_SHIFT - 1))) >> TW_SHIFT;
    if (r > top) r = top;
    return r;
  endfunction

  function automatic sin_rom_t build_rom();
    sin_rom_t        rom;
    longint unsigned x;
    for (int k = 0; k <= FULL_N / 8; k++) begin
      x = (PI_Q31 * 64'd2 * longint'(k) + FULL_N / 2) / FULL_N;
      rom[QUART_N-k] = TWIDDLE_BITS'(to_twiddle(series_q31(x, 1'b0)));
      rom[k]         = TWIDDLE_BITS'(to_twiddle(series_q31(x, 1'b1)));
    end
    return rom;
  endfunction

  localparam sin_rom_t SIN_ROM = build_rom();

  // sine of 2*pi*idx/FULL_N, folded from the quarter wave
  function automatic logic signed [TWIDDLE_BITS-1:0] rom_sin(logic [ADDR_BITS-1:0] idx);
    logic [1:0]                    quad;
    logic [ADDR_BITS-3:0]          r;
    logic [ADDR_BITS-2:0]          ri;
    logic signed [TWIDDLE_BITS-1:0] v;
    quad = idx[ADDR_BITS-1 -: 2];
    r    = idx[ADDR_BITS-3:0];
    ri   = quad[0] ? ((ADDR_BITS-1)'(QUART_N) - {1'b0, r}) : {1'b0, r};
    v    = SIN_ROM[ri];
    return quad[1] ? -v : v;
  endfunction

  function automatic logic [ADDR_BITS-1:0] rev_bits(logic [ADDR_BITS-1:0] v,
                                                    logic [LOG_BITS-1:0] lg);
    logic [ADDR_BITS-1:0] r;
    for (int b = 0; b < ADDR_BITS; b++) r[b] = v[ADDR_BITS-1-b];
    return r >> (LOG_BITS'(ADDR_BITS) - lg);
  endfunction

  function automatic logic signed [INTERNAL_BITS-1:0] sat_word(logic signed [ACC_BITS-1:0] v);
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    hi = ACC_BITS'((64'sd1 <<< (INTERNAL_BITS - 1)) - 64'sd1);
    lo = -hi - ACC_BITS'(1);
    if (v > hi) return INTERNAL_BITS'(hi);
    if (v < lo) return INTERNAL_BITS'(lo);
    return INTERNAL_BITS'(v);
  endfunction

endpackage

FILE: design/r2fft_if.sv
// Channel interfaces of the radix-2 FFT block: input items and results.
// Depends on r2fft_pkg for field widths.
interface r2fft_in_if import r2fft_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic                           operation;
  logic signed [SAMPLE_BITS-1:0]  sample_real;
  logic signed [SAMPLE_BITS-1:0]  sample_imag;
  modport source (output valid, operation, sample_real, sample_imag, input ready);
  modport sink   (input valid, operation, sample_real, sample_imag, output ready);
endinterface

interface r2fft_out_if import r2fft_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [INTERNAL_BITS-1:0] result_real;
  logic signed [INTERNAL_BITS-1:0] result_imag;
  logic                            last_result;
  logic                            status;
  modport source (output valid, result_real, result_imag, last_result, status, input ready);
  modport sink   (input valid, result_real, result_imag, last_result, status, output ready);
endinterface

FILE: design/radix2_complex_fft.sv
// In-place radix-2 DIT complex FFT over a frame of n = 2^log_size samples (1..10).
// Loads go straight into the frame RAM; the load that completes the frame starts
// the transform, which holds the input off through bit-reverse reordering and the
// butterfly passes, paced by the single frame RAM port pair and the one shared
// twiddle multiplier (four products per butterfly). A read of a waiting frame passes
// the RAM read register and the result register; an empty read only the latter.
// Config writes must only be made while the block is idle.
module radix2_complex_fft import r2fft_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  r2fft_in_if.sink                 in_i,
  r2fft_out_if.source              out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);
  cmd_t  cmd;
  stat_t stat;

  r2fft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  r2fft_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_real_i (in_i.sample_real),
    .sample_imag_i (in_i.sample_imag),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .result_real_o (out_o.result_real),
    .result_imag_o (out_o.result_imag),
    .last_result_o (out_o.last_result),
    .status_o      (out_o.status)
  );
endmodule

FILE: design/r2fft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: design/r2fft_datapath.sv
// Datapath of the radix-2 FFT: config registers, counters, frame RAM,
// shared twiddle multiplier, butterfly adders and result register. Uses r2fft_pkg.
module r2fft_datapath import r2fft_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmd_t                            cmd_i,
  output stat_t                           stat_o,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_imag_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic signed [INTERNAL_BITS-1:0] result_real_o,
  output logic signed [INTERNAL_BITS-1:0] result_imag_o,
  output logic                            last_result_o,
  output logic                            status_o
);
  logic                 inverse_q;
  logic [LOG_BITS-1:0]  log_size_q;
  logic [ADDR_BITS-1:0] lc_q, lc_d, rc_q, rc_d;
  logic                 ready_q, ready_d;
  logic [LOG_BITS-1:0]  flog_q, flog_d;
  logic                 finv_q, finv_d;
  logic [ADDR_BITS-1:0] idx_q, idx_d;
  logic [ADDR_BITS-2:0] bfly_q, bfly_d;
  logic [LOG_BITS-1:0]  stage_q, stage_d;
  logic [2:0]           mcnt_q, mcnt_d;
  logic                 pend_last_q;
  logic [WORD_BITS-1:0] top_q;
  logic signed [TWIDDLE_BITS-1:0] sn_q, cs_q;
  logic signed [ACC_BITS-1:0]     prod_q, dx_q, dy_q;

  logic                 out_valid_q;
  logic signed [INTERNAL_BITS-1:0] res_re_q, res_im_q;
  logic                 res_last_q, res_stat_q;

  logic [LOG_BITS-1:0]  eff_log;
  logic [ADDR_BITS:0]   n_cur, n_frame, lc_inc, rc_inc;
  logic [ADDR_BITS-1:0] rev, mask, bf_ext, bi, bk, tw_h;
  logic                 we;
  logic [ADDR_BITS-1:0] waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  logic signed [INTERNAL_BITS-1:0] b_re, b_im, t_re, t_im;
  logic signed [TWIDDLE_BITS-1:0]  tw_op, sn_v;
  logic signed [INTERNAL_BITS-1:0] b_op;
  logic [TWIDDLE_BITS-1:0]         ua;
  logic [INTERNAL_BITS-1:0]        ub;
  logic [TWIDDLE_BITS+INTERNAL_BITS:0] pmag;
  logic [ACC_BITS-1:0]             pm;
  logic signed [ACC_BITS-1:0]      prod_v, sum_re, sum_im, fin_re, fin_im;
  logic                            neg;

  always_comb begin
    if (log_size_q == '0) eff_log = LOG_BITS'(1);
    else if (log_size_q > LOG_BITS'(MAX_LOG_SIZE)) eff_log = LOG_BITS'(MAX_LOG_SIZE);
    else eff_log = log_size_q;
  end

  assign n_cur   = (ADDR_BITS+1)'(1) << eff_log;
  assign n_frame = (ADDR_BITS+1)'(1) << flog_q;
  assign lc_inc  = {1'b0, lc_q} + (ADDR_BITS+1)'(1);
  assign rc_inc  = {1'b0, rc_q} + (ADDR_BITS+1)'(1);
  assign rev     = rev_bits(idx_q, flog_q);

  // butterfly addressing: i = group*2k + j, partner i + k
  assign mask   = (ADDR_BITS'(1) << stage_q) - ADDR_BITS'(1);
  assign bf_ext = {1'b0, bfly_q};
  assign bi     = ((bf_ext & ~mask) << 1) | (bf_ext & mask);
  assign bk     = bi | (ADDR_BITS'(1) << stage_q);
  assign tw_h   = (bf_ext & mask) << (LOG_BITS'(ADDR_BITS - 1) - stage_q);
  assign sn_v   = rom_sin(tw_h);

  assign b_re = rdata[WORD_BITS-1 -: INTERNAL_BITS];
  assign b_im = rdata[INTERNAL_BITS-1:0];
  assign t_re = top_q[WORD_BITS-1 -: INTERNAL_BITS];
  assign t_im = top_q[INTERNAL_BITS-1:0];

  // product order: sn*bim, c*bre, c*bim, sn*bre
  always_comb begin
    tw_op = (mcnt_q[1:0] == 2'd0 || mcnt_q[1:0] == 2'd3) ? sn_q : cs_q;
    b_op  = (mcnt_q[1:0] == 2'd0 || mcnt_q[1:0] == 2'd2) ? b_im : b_re;
    neg   = tw_op[TWIDDLE_BITS-1] ^ b_op[INTERNAL_BITS-1];
    ua    = tw_op[TWIDDLE_BITS-1] ? TWIDDLE_BITS'(-tw_op) : TWIDDLE_BITS'(tw_op);
    ub    = b_op[INTERNAL_BITS-1] ? INTERNAL_BITS'(-b_op) : INTERNAL_BITS'(b_op);
    pmag  = (TWIDDLE_BITS+INTERNAL_BITS+1)'(ua * ub)
          + ((TWIDDLE_BITS+INTERNAL_BITS+1)'(1) << (TWIDDLE_BITS - 2));
    pm    = ACC_BITS'(pmag >> (TWIDDLE_BITS - 1));
    prod_v = neg ? -$signed(pm) : $signed(pm);
  end

  always_comb begin
    if (cmd_i.bf_wr_t) begin
      sum_re = ACC_BITS'(t_re) + dx_q;
      sum_im = ACC_BITS'(t_im) + dy_q;
    end else begin
      sum_re = ACC_BITS'(t_re) - dx_q;
      sum_im = ACC_BITS'(t_im) - dy_q;
    end
    fin_re = finv_q ? sum_re : (sum_re >>> 1);
    fin_im = finv_q ? sum_im : (sum_im >>> 1);
  end

  always_comb begin
    we    = 1'b0;
    waddr = lc_q;
    wdata = {INTERNAL_BITS'(sample_real_i), INTERNAL_BITS'(sample_imag_i)};
    raddr = rc_q;
    if (cmd_i.load_acc) we = 1'b1;
    if (cmd_i.br_rd_a) raddr = idx_q;
    if (cmd_i.br_rd_b) raddr = rev;
    if (cmd_i.br_wr_a) begin
      we = 1'b1; waddr = idx_q; wdata = rdata;
    end
    if (cmd_i.br_wr_b) begin
      we = 1'b1; waddr = rev; wdata = top_q;
    end
    if (cmd_i.bf_rd_a) raddr = bi;
    if (cmd_i.bf_rd_b || cmd_i.bf_mul) raddr = bk;
    if (cmd_i.bf_wr_t || cmd_i.bf_wr_b) begin
      we    = 1'b1;
      waddr = cmd_i.bf_wr_t ? bi : bk;
      wdata = {sat_word(fin_re), sat_word(fin_im)};
    end
  end

  r2fft_ram #(.WIDTH(WORD_BITS), .DEPTH(FULL_N)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    lc_d    = lc_q;
    rc_d    = rc_q;
    ready_d = ready_q;
    flog_d  = flog_q;
    finv_d  = finv_q;
    idx_d   = idx_q;
    bfly_d  = bfly_q;
    stage_d = stage_q;
    mcnt_d  = mcnt_q;
    if (cmd_i.load_acc) begin
      ready_d = 1'b0;
      rc_d    = '0;
      lc_d    = ADDR_BITS'(lc_inc);
      if (lc_inc >= n_cur) begin
        lc_d    = '0;
        flog_d  = eff_log;
        finv_d  = inverse_q;
        idx_d   = '0;
        bfly_d  = '0;
        stage_d = '0;
      end
    end
    if (cmd_i.read_acc && ready_q) begin
      if (rc_inc >= n_frame) begin
        ready_d = 1'b0;
        rc_d    = '0;
      end else begin
        rc_d = ADDR_BITS'(rc_inc);
      end
    end
    if (cmd_i.br_wr_b || cmd_i.br_skip) idx_d = idx_q + ADDR_BITS'(1);
    if (cmd_i.bf_rd_b) mcnt_d = '0;
    if (cmd_i.bf_mul) mcnt_d = mcnt_q + 3'd1;
    if (cmd_i.bf_wr_b) begin
      if (stat_o.bf_last) begin
        bfly_d  = '0;
        stage_d = stage_q + LOG_BITS'(1);
        if (stat_o.stage_last) ready_d = 1'b1;
      end else begin
        bfly_d = bfly_q + (ADDR_BITS-1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q   <= 1'b0;
      log_size_q  <= LOG_BITS'(MAX_LOG_SIZE);
      lc_q        <= '0;
      rc_q        <= '0;
      ready_q     <= 1'b0;
      flog_q      <= LOG_BITS'(1);
      finv_q      <= 1'b0;
      idx_q       <= '0;
      bfly_q      <= '0;
      stage_q     <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INVERSE_MODE: inverse_q  <= cfg_data_i[0];
          REG_LOG_SIZE:     log_size_q <= cfg_data_i;
          default: ;
        endcase
      end
      lc_q    <= lc_d;
      rc_q    <= rc_d;
      ready_q <= ready_d;
      flog_q  <= flog_d;
      finv_q  <= finv_d;
      idx_q   <= idx_d;
      bfly_q  <= bfly_d;
      stage_q <= stage_d;
      mcnt_q  <= mcnt_d;
      if ((cmd_i.read_acc && !ready_q) || cmd_i.read_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_acc) pend_last_q <= (rc_inc >= n_frame);
    if (cmd_i.br_rd_b || cmd_i.bf_rd_b) top_q <= rdata;
    if (cmd_i.bf_rd_a) begin
      sn_q <= finv_q ? -sn_v : sn_v;
      cs_q <= rom_sin(tw_h + ADDR_BITS'(QUART_N));
    end
    if (cmd_i.bf_mul) begin
      prod_q <= prod_v;
      case (mcnt_q)
        3'd1:    dx_q <= prod_q;
        3'd2:    dx_q <= dx_q + prod_q;
        3'd3:    dy_q <= prod_q;
        3'd4:    dy_q <= dy_q - prod_q;
        default: ;
      endcase
    end
    if (cmd_i.read_acc && !ready_q) begin
      res_re_q   <= '0;
      res_im_q   <= '0;
      res_last_q <= 1'b0;
      res_stat_q <= STATUS_EMPTY;
    end else if (cmd_i.read_out) begin
      res_re_q   <= b_re;
      res_im_q   <= b_im;
      res_last_q <= pend_last_q;
      res_stat_q <= STATUS_OK;
    end
  end

  assign stat_o.load_full   = (lc_inc >= n_cur);
  assign stat_o.frame_ready = ready_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.br_swap     = (idx_q < rev);
  assign stat_o.br_last     = (idx_q == ADDR_BITS'(n_frame - (ADDR_BITS+1)'(1)));
  assign stat_o.mul_done    = (mcnt_q == 3'd4);
  assign stat_o.bf_last     = (bfly_q == (ADDR_BITS-1)'((n_frame >> 1) - (ADDR_BITS+1)'(1)));
  assign stat_o.stage_last  = (stage_q == flog_q - LOG_BITS'(1));

  assign out_valid_o   = out_valid_q;
  assign result_real_o = res_re_q;
  assign result_imag_o = res_im_q;
  assign last_result_o = res_last_q;
  assign status_o      = res_stat_q;
endmodule

FILE: design/r2fft_ctrl.sv
// Controller of the radix-2 FFT: sequences load, read, bit-reverse
// reordering and butterfly passes. Uses r2fft_pkg.
module r2fft_ctrl import r2fft_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_op_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);
  state_e state_q, state_d;
  logic   acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
    acc        = in_valid_i && in_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_op_i == OP_LOAD) begin
          cmd_o.load_acc = 1'b1;
          if (stat_i.load_full) state_d = ST_BR_RA;
        end else if (acc) begin
          cmd_o.read_acc = 1'b1;
          if (stat_i.frame_ready) state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read_out = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_BR_RA: begin
        if (stat_i.br_swap) begin
          cmd_o.br_rd_a = 1'b1;
          state_d       = ST_BR_RB;
        end else begin
          cmd_o.br_skip = 1'b1;
          if (stat_i.br_last) state_d = ST_BF_RA;
        end
      end
      ST_BR_RB: begin
        cmd_o.br_rd_b = 1'b1;
        state_d       = ST_BR_WA;
      end
      ST_BR_WA: begin
        cmd_o.br_wr_a = 1'b1;
        state_d       = ST_BR_WB;
      end
      ST_BR_WB: begin
        cmd_o.br_wr_b = 1'b1;
        state_d       = stat_i.br_last ? ST_BF_RA : ST_BR_RA;
      end
      ST_BF_RA: begin
        cmd_o.bf_rd_a = 1'b1;
        state_d       = ST_BF_RB;
      end
      ST_BF_RB: begin
        cmd_o.bf_rd_b = 1'b1;
        state_d       = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd_o.bf_mul = 1'b1;
        if (stat_i.mul_done) state_d = ST_BF_WT;
      end
      ST_BF_WT: begin
        cmd_o.bf_wr_t = 1'b1;
        state_d       = ST_BF_WB;
      end
      ST_BF_WB: begin
        cmd_o.bf_wr_b = 1'b1;
        state_d = (stat_i.bf_last && stat_i.stage_last) ? ST_IDLE : ST_BF_RA;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

FILE: design/r2fft_checker.sv
// Port-level checker for the radix-2 FFT block, bound to the top level.
// Uses r2fft_pkg and the macros in radix2_complex_fft_defines.svh.
`include "radix2_complex_fft_defines.svh"

module r2fft_checker import r2fft_pkg::*; (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [INTERNAL_BITS-1:0] result_real_i,
  input logic signed [INTERNAL_BITS-1:0] result_imag_i,
  input logic                            last_result_i,
  input logic                            status_i
);
  // a result held back blocks new transactions
  `R2FFT_ASSERT_NOW(a_ready_needs_free_out, in_ready_i && out_valid_i, out_ready_i)
  // an empty read carries zero payload
  `R2FFT_ASSERT_NOW(a_empty_zero, out_valid_i && status_i == STATUS_EMPTY, result_real_i == '0 && result_imag_i == '0 && !last_result_i)
  // the end of frame mark only comes with real data
  `R2FFT_ASSERT_NOW(a_last_is_data, out_valid_i && last_result_i, status_i == STATUS_OK)
  `R2FFT_ASSERT_NEXT(a_valid_holds, out_valid_i && !out_ready_i, out_valid_i)
  `R2FFT_ASSERT_NEXT(a_payload_holds, out_valid_i && !out_ready_i, $stable(result_real_i) && $stable(result_imag_i) && $stable(status_i))
endmodule

bind radix2_complex_fft r2fft_checker u_r2fft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_real_i (out_o.result_real),
  .result_imag_i (out_o.result_imag),
  .last_result_i (out_o.last_result),
  .status_i      (out_o.status)
);
